@@ hw/rtl/ssbr_pkg.sv @@
// Shared constants, payload types and controller/datapath command types
// for the subset-sum reachability core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssbr_pkg;

    localparam int SUM_CAPACITY = 4096;
    localparam int SUM_W        = 12;
    localparam int WORD_W       = 64;
    localparam int OFF_W        = 6;
    localparam int IDX_W        = 6;
    localparam int STORE_WORDS  = SUM_CAPACITY / WORD_W;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = PADDR_W - 2;

    localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(SUM_CAPACITY - 1);

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_TEST = 2'd1;
    localparam logic [1:0] OP_DUMP = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_MAX_SUM = REG_IDX_W'(0);

    typedef struct packed {
        logic [1:0]       op;
        logic [SUM_W-1:0] amount;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] word_data;
        logic              last;
    } t_out_item;

    typedef enum logic [1:0] {
        RES_ADD,
        RES_TEST,
        RES_DUMP
    } t_res_kind;

    typedef struct packed {
        logic      accept;
        logic      b_prime;
        logic      add_step;
        logic      inc_idx;
        logic      out_load;
        t_res_kind out_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic idx_zero;
        logic idx_top;
        logic over;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hw/rtl/ssbr_ctrl.sv @@
// Request sequencer for the subset-sum reachability core.
// Drives datapath commands from its status; depends on ssbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssbr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [1:0]        i_in_op,
    input  ssbr_pkg::t_dp_stat     i_stat,
    output logic                   o_in_ready,
    output ssbr_pkg::t_dp_cmd      o_cmd
);
    import ssbr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_PRIME,
        S_ADD_RUN,
        S_ADD_LAST,
        S_ADD_OUT,
        S_TEST_RD,
        S_TEST_OUT,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.out_kind = RES_ADD;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_op == OP_ADD) begin
                        n_state = S_ADD_PRIME;
                    end else if (i_in_op == OP_TEST) begin
                        n_state = S_TEST_RD;
                    end else if (i_in_op == OP_DUMP) begin
                        n_state = S_DUMP_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ADD_PRIME: begin
                o_cmd.b_prime = 1'b1;
                n_state       = S_ADD_RUN;
            end
            S_ADD_RUN: begin
                o_cmd.add_step = 1'b1;
                if (i_stat.idx_zero) begin
                    n_state = S_ADD_LAST;
                end
            end
            S_ADD_LAST: begin
                n_state = S_ADD_OUT;
            end
            S_ADD_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = RES_ADD;
                    n_state        = S_IDLE;
                end
            end
            S_TEST_RD: begin
                n_state = S_TEST_OUT;
            end
            S_TEST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = RES_TEST;
                    n_state        = S_IDLE;
                end
            end
            S_DUMP_RD: begin
                n_state = S_DUMP_OUT;
            end
            S_DUMP_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = RES_DUMP;
                    if (i_stat.over || i_stat.idx_top) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.inc_idx = 1'b1;
                        n_state       = S_DUMP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/ssbr_datapath.sv @@
// Datapath: reachability word store with two registered read ports,
// shift-merge write path, limit register and result register. Uses ssbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssbr_datapath (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  ssbr_pkg::t_in_item             i_in_data,
    input  ssbr_pkg::t_dp_cmd              i_cmd,
    input  wire logic                      i_cfg_we,
    input  wire logic [ssbr_pkg::SUM_W-1:0] i_cfg_max_sum,
    input  wire logic                      i_out_ready,
    output ssbr_pkg::t_dp_stat             o_stat,
    output logic [ssbr_pkg::SUM_W-1:0]     o_max_sum,
    output logic                           o_out_valid,
    output ssbr_pkg::t_out_item            o_out_data
);
    import ssbr_pkg::*;

    logic [WORD_W-1:0]      r_mem [STORE_WORDS];
    logic [STORE_WORDS-1:0] r_valid;
    logic [SUM_W-1:0]       r_max_sum;
    logic [SUM_W-1:0]       r_amount;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_wa;
    logic                   r_wv;
    logic [WORD_W-1:0]      r_rda;
    logic [WORD_W-1:0]      r_rdb;
    logic [WORD_W-1:0]      r_prev_b;
    logic                   r_hit;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [SUM_W-1:0]  n_max_sum;
    t_out_item         n_out;
    logic [IDX_W-1:0]  top;
    logic [IDX_W-1:0]  whole;
    logic [OFF_W-1:0]  off;
    logic [IDX_W:0]    b_diff;
    logic [IDX_W:0]    b_full;
    logic              b_neg;
    logic [IDX_W-1:0]  b_addr;
    logic [WORD_W-1:0] moved_lo;
    logic [WORD_W-1:0] moved_hi;
    logic [WORD_W-1:0] merged;
    logic [WORD_W-1:0] tail_mask;
    logic [WORD_W-1:0] head_mask;
    logic [WORD_W-1:0] wr_word;
    logic              over;
    logic              out_free;

    assign top    = r_max_sum[SUM_W-1:OFF_W];
    assign whole  = r_amount[SUM_W-1:OFF_W];
    assign off    = r_amount[OFF_W-1:0];
    assign b_diff = {1'b0, r_idx} - {1'b0, whole};
    assign b_full = i_cmd.b_prime ? b_diff : (b_diff - (IDX_W+1)'(1));
    assign b_neg  = b_full[IDX_W];
    assign b_addr = b_full[IDX_W-1:0];

    assign moved_lo  = r_prev_b << off;
    assign moved_hi  = (off != '0) ? (r_rdb >> (7'(WORD_W) - {1'b0, off})) : '0;
    assign merged    = r_rda | moved_lo | moved_hi;
    assign tail_mask = {WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - r_max_sum[OFF_W-1:0]);
    assign head_mask = {WORD_W{1'b1}} << off;
    assign wr_word   = (r_wa == top) ? (merged & tail_mask) : merged;

    assign over      = (r_amount > r_max_sum);
    assign out_free  = !r_out_valid || i_out_ready;
    assign n_max_sum = (i_cfg_max_sum > SUM_LIMIT) ? SUM_LIMIT : i_cfg_max_sum;

    assign o_stat.out_free = out_free;
    assign o_stat.idx_zero = (r_idx == '0);
    assign o_stat.idx_top  = (r_idx == top);
    assign o_stat.over     = over;
    assign o_max_sum       = r_max_sum;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    always_comb begin
        n_out = '0;
        n_out.last = 1'b1;
        case (i_cmd.out_kind)
            RES_ADD: begin
                n_out.hit = r_hit;
            end
            RES_TEST: begin
                n_out.hit = r_rda[off] && !over;
            end
            RES_DUMP: begin
                if (!over) begin
                    n_out.word_index = r_idx;
                    n_out.word_data  = (r_idx == whole) ? (r_rda & head_mask) : r_rda;
                    n_out.last       = (r_idx == top);
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sum   <= SUM_LIMIT;
            r_valid     <= '0;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_sum <= n_max_sum;
                r_valid   <= '0;
            end else if (r_wv) begin
                r_valid[r_wa] <= 1'b1;
            end
            r_wv <= i_cmd.add_step;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wv) begin
            r_mem[r_wa] <= wr_word;
            if (r_wa == top) begin
                r_hit <= wr_word[r_max_sum[OFF_W-1:0]];
            end
        end
        if (r_valid[r_idx]) begin
            r_rda <= r_mem[r_idx];
        end else begin
            r_rda <= (r_idx == '0) ? WORD_W'(1) : '0;
        end
        if (b_neg) begin
            r_rdb <= '0;
        end else if (r_valid[b_addr]) begin
            r_rdb <= r_mem[b_addr];
        end else begin
            r_rdb <= (b_addr == '0) ? WORD_W'(1) : '0;
        end
        r_prev_b <= r_rdb;
        r_wa     <= r_idx;
        if (i_cmd.accept) begin
            r_amount <= i_in_data.amount;
            r_idx    <= (i_in_data.op == OP_ADD) ? top : i_in_data.amount[SUM_W-1:OFF_W];
        end else if (i_cmd.add_step) begin
            r_idx <= r_idx - IDX_W'(1);
        end else if (i_cmd.inc_idx) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/subset_sum_bitset_reachability_core.sv @@
// One request is in flight at a time; the add pass walks the used store
// words one per cycle, top word first.
// Reset (synchronous, active low): max_sum = 4095, bitmap holds sum zero
// only through per-word valid flags cleared at once; no clearing pass.
// Top level: APB register port, controller and datapath; uses ssbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module subset_sum_bitset_reachability_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  ssbr_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output ssbr_pkg::t_out_item                o_out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ssbr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ssbr_pkg::PDATA_W-1:0]  pwdata,
    output logic [ssbr_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import ssbr_pkg::*;

    t_dp_cmd              cmd;
    t_dp_stat             stat;
    logic                 cfg_we;
    logic [SUM_W-1:0]     max_sum;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_MAX_SUM);
    assign prdata  = (reg_idx == REG_MAX_SUM) ? PDATA_W'(max_sum) : '0;

    ssbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.op),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ssbr_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_cmd         (cmd),
        .i_cfg_we      (cfg_we),
        .i_cfg_max_sum (pwdata[SUM_W-1:0]),
        .i_out_ready   (i_out_ready),
        .o_stat        (stat),
        .o_max_sum     (max_sum),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_data.op == OP_ADD || i_in_data.op == OP_TEST
            || i_in_data.op == OP_DUMP)) |=> !o_in_ready)
        else $error("core ready right after taking a request");

    a_dump_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.word_index != '0) |-> !o_out_data.hit)
        else $error("hit set on a dumped word");

    a_hit_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.hit) |-> (o_out_data.word_data == '0 && o_out_data.last))
        else $error("hit result carries word data or is not last");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten while held");

endmodule

`default_nettype wire
